// ----- rtl/core/rfha_pkg.sv -----
`default_nettype none
package rfha_pkg;

  localparam int MAX_TRACKS = 64;
  localparam int COORD_W    = 17;
  localparam int ROAD_W     = 35;
  localparam int OUT_IDX_W  = 6;
  localparam int IDX_W      = $clog2(MAX_TRACKS);
  localparam int CNT_W      = $clog2(MAX_TRACKS + 1);
  localparam int ABS_W      = COORD_W;
  localparam int SQ_W       = 2 * ABS_W;
  localparam int DIST_W     = SQ_W + 1;
  localparam int ROAD_RESET = 6400;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DEC   = 4'b1000
  } state_t;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [IDX_W-1:0]          idx_t;
  typedef logic [CNT_W-1:0]          cnt_t;

endpackage
`default_nettype wire

// ----- rtl/core/road_following_hit_assigner_unit.sv -----
`default_nettype none
// Road-following hit assigner: nearest-neighbour track following on hits
// sorted by drift coordinate.
// Input channel in_*: in_tdata = {hit_z, hit_y}, in_tuser = start_event.
// Result channel out_*: out_tdata = track_index, out_tuser = {table_overflow,
// opened_track}. One result per accepted hit, in order.
// Config channel cfg_*: writes road_dist_sq; always ready, write only when idle.
// Track end points live in a 64-entry synchronous RAM. Each hit scans the
// open tracks one entry per cycle through a three-stage read / square /
// add-compare pipe, then writes the chosen entry back and registers the
// result in the output register. The next hit can transfer only after the
// previous one is written back; an empty table or start_event set skips the
// scan.
// Reset (rst_n low, synchronous) empties the track table, sets the threshold
// to 6400 and drops any pending result. The RAM needs no clearing: only
// entries below the open-track count are read. When out_tready is low the
// result holds in the output register; a following hit may still be taken
// and scanned, and waits before write-back until the register frees.
module road_following_hit_assigner_unit (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [39:0] in_tdata,   // [16:0] hit_y, [33:17] hit_z, [39:34] zero
  input  wire  [0:0]  in_tuser,   // [0] start_event
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [7:0]  out_tdata,  // [5:0] track_index, [7:6] zero
  output logic [1:0]  out_tuser,  // [0] opened_track, [1] table_overflow
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [34:0] cfg_data    // [34:0] road_dist_sq
);

  rfha_pkg::state_t state_r, state_nxt;

  logic [rfha_pkg::ROAD_W-1:0] road_r;
  rfha_pkg::cnt_t   open_r, open_nxt;
  rfha_pkg::coord_t hy_r, hz_r;
  rfha_pkg::idx_t   scan_idx_r, scan_idx_nxt;

  logic [2*rfha_pkg::COORD_W-1:0] mem [rfha_pkg::MAX_TRACKS];
  logic [2*rfha_pkg::COORD_W-1:0] mem_q_r;
  logic                           rd_en;
  logic                           wr_en;
  rfha_pkg::idx_t                 wr_addr;

  logic           v0_r;
  rfha_pkg::idx_t idx0_r;
  logic           v1_r;
  rfha_pkg::idx_t idx1_r;
  logic [rfha_pkg::SQ_W-1:0] sqy_r, sqz_r;

  logic                        have_r;
  logic [rfha_pkg::DIST_W-1:0] best_d_r;
  rfha_pkg::idx_t              best_r;

  logic                           out_valid_r;
  logic [rfha_pkg::OUT_IDX_W-1:0] out_idx_r;
  logic                           out_open_r, out_ovf_r;

  logic in_xfer, out_free, dec_fire;

  rfha_pkg::coord_t q_y, q_z;
  logic signed [rfha_pkg::COORD_W:0] dy_s, dz_s;
  logic [rfha_pkg::ABS_W-1:0]        dy_a, dz_a;
  logic [rfha_pkg::DIST_W-1:0]       scan_d;

  logic           need_new, room, dec_opened, dec_ovf;
  rfha_pkg::idx_t dec_idx;

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == rfha_pkg::ST_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign dec_fire   = (state_r == rfha_pkg::ST_DEC) && out_free;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_idx_r};
  assign out_tuser  = {out_ovf_r, out_open_r};

  assign rd_en = (state_r == rfha_pkg::ST_SCAN);

  // Square stage inputs
  assign q_y  = mem_q_r[rfha_pkg::COORD_W-1:0];
  assign q_z  = mem_q_r[2*rfha_pkg::COORD_W-1:rfha_pkg::COORD_W];
  assign dy_s = {q_y[rfha_pkg::COORD_W-1], q_y} - {hy_r[rfha_pkg::COORD_W-1], hy_r};
  assign dz_s = {q_z[rfha_pkg::COORD_W-1], q_z} - {hz_r[rfha_pkg::COORD_W-1], hz_r};
  assign dy_a = dy_s[rfha_pkg::COORD_W] ? rfha_pkg::ABS_W'(-dy_s)
                                         : rfha_pkg::ABS_W'(dy_s);
  assign dz_a = dz_s[rfha_pkg::COORD_W] ? rfha_pkg::ABS_W'(-dz_s)
                                         : rfha_pkg::ABS_W'(dz_s);

  assign scan_d = {1'b0, sqy_r} + {1'b0, sqz_r};

  // Decision after the scan
  always_comb begin
    need_new   = !have_r || (best_d_r > rfha_pkg::DIST_W'(road_r));
    room       = (open_r != rfha_pkg::CNT_W'(rfha_pkg::MAX_TRACKS));
    dec_idx    = best_r;
    dec_opened = 1'b0;
    dec_ovf    = 1'b0;
    if (need_new) begin
      if (room) begin
        dec_idx    = rfha_pkg::IDX_W'(open_r);
        dec_opened = 1'b1;
      end else begin
        dec_ovf = 1'b1;
      end
    end
  end

  assign wr_en   = dec_fire;
  assign wr_addr = dec_idx;

  always_comb begin
    state_nxt    = state_r;
    open_nxt     = open_r;
    scan_idx_nxt = scan_idx_r;
    case (state_r)
      rfha_pkg::ST_IDLE: begin
        if (in_xfer) begin
          scan_idx_nxt = '0;
          if (in_tuser[0]) begin
            open_nxt  = '0;
            state_nxt = rfha_pkg::ST_DEC;
          end else if (open_r == '0) begin
            state_nxt = rfha_pkg::ST_DEC;
          end else begin
            state_nxt = rfha_pkg::ST_SCAN;
          end
        end
      end
      rfha_pkg::ST_SCAN: begin
        scan_idx_nxt = scan_idx_r + 1'b1;
        if (rfha_pkg::CNT_W'(scan_idx_r) + 1'b1 == open_r) begin
          state_nxt = rfha_pkg::ST_DRAIN;
        end
      end
      rfha_pkg::ST_DRAIN: begin
        if (!v0_r && !v1_r) begin
          state_nxt = rfha_pkg::ST_DEC;
        end
      end
      rfha_pkg::ST_DEC: begin
        if (out_free) begin
          if (dec_opened) begin
            open_nxt = open_r + 1'b1;
          end
          state_nxt = rfha_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rfha_pkg::ST_IDLE;
    endcase
  end

  // Track end RAM
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {hz_r, hy_r};
    end
    if (rd_en) begin
      mem_q_r <= mem[scan_idx_r];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rfha_pkg::ST_IDLE;
      open_r      <= '0;
      road_r      <= rfha_pkg::ROAD_W'(rfha_pkg::ROAD_RESET);
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      have_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      open_r  <= open_nxt;
      v0_r    <= rd_en;
      v1_r    <= v0_r;
      if (cfg_valid && cfg_ready) begin
        road_r <= cfg_data;
      end
      if (in_xfer) begin
        have_r <= 1'b0;
      end else if (v1_r && (!have_r || scan_d < best_d_r)) begin
        have_r <= 1'b1;
      end
      if (dec_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload and pipe data
  always_ff @(posedge clk) begin
    scan_idx_r <= scan_idx_nxt;
    idx0_r     <= scan_idx_r;
    idx1_r     <= idx0_r;
    sqy_r      <= dy_a * dy_a;
    sqz_r      <= dz_a * dz_a;
    if (in_xfer) begin
      hy_r <= in_tdata[rfha_pkg::COORD_W-1:0];
      hz_r <= in_tdata[2*rfha_pkg::COORD_W-1:rfha_pkg::COORD_W];
    end
    // keep the first minimum: ties stay on the lower index
    if (v1_r && (!have_r || scan_d < best_d_r)) begin
      best_d_r <= scan_d;
      best_r   <= idx1_r;
    end
    if (dec_fire) begin
      out_idx_r  <= rfha_pkg::OUT_IDX_W'(dec_idx);
      out_open_r <= dec_opened;
      out_ovf_r  <= dec_ovf;
    end
  end

endmodule
`default_nettype wire

// ----- sim/road_following_hit_assigner_unit_test.sv -----
`default_nettype none
module road_following_hit_assigner_unit_test;

  localparam int  RESET_CYCLES  = 11;
  localparam int  SETTLE_CYCLES = 80;
  localparam int  LONG_HOLD     = 400;
  localparam int  CYCLE_LIMIT   = 1000000;
  localparam int  RANDOM_HITS   = 1150;
  localparam int  N_ROWS        = 14;
  localparam logic [rfha_pkg::ROAD_W-1:0] ROAD_MAX = '1;

  typedef struct packed {
    logic [rfha_pkg::OUT_IDX_W-1:0] track;
    logic                           opened;
    logic                           overflow;
  } assignment_t;

  typedef struct {
    int start;
    int y;
    int z;
    int typed;
    int track;
    int opened;
    int overflow;
  } hit_row_t;

  // reset threshold is 6400 throughout this table
  hit_row_t hit_rows [N_ROWS] = '{
    '{1, 0, 0, 1, 0, 1, 0},              // empty table opens track 0
    '{0, 80, 0, 1, 0, 0, 0},             // exactly on the road edge
    '{0, 161, 0, 1, 1, 1, 0},            // just off the road
    '{0, -65536, -65536, 1, 2, 1, 0},
    '{0, 65535, 65535, 1, 3, 1, 0},
    '{0, 65535, -65536, 1, 4, 1, 0},
    '{0, -65536, 65535, 1, 5, 1, 0},
    '{0, -65535, -65536, 1, 2, 0, 0},
    '{0, 100, -40, 0, 0, 0, 0},
    '{1, 0, 0, 1, 0, 1, 0},              // start clears a busy table
    '{0, 0, 160, 1, 1, 1, 0},
    '{0, 0, 80, 1, 0, 0, 0},             // equal distance, lower index wins
    '{0, 5000, 5000, 0, 0, 0, 0},
    '{1, 65535, -65536, 1, 0, 1, 0}
  };

  logic                        clk        = 1'b0;
  logic                        rst_n      = 1'b0;
  logic                        in_tvalid  = 1'b0;
  logic                        in_tready;
  logic [39:0]                 in_tdata   = '0;   // [16:0] hit_y, [33:17] hit_z, [39:34] zero
  logic [0:0]                  in_tuser   = '0;   // [0] start_event
  logic                        out_tvalid;
  logic                        out_tready = 1'b0;
  logic [7:0]                  out_tdata;         // [5:0] track_index, [7:6] zero
  logic [1:0]                  out_tuser;         // [0] opened_track, [1] table_overflow
  logic                        cfg_valid  = 1'b0;
  logic                        cfg_ready;
  logic [rfha_pkg::ROAD_W-1:0] cfg_data   = '0;   // [34:0] road_dist_sq

  // fixed expectation that travels alongside the current transfer
  logic        typed_on  = 1'b0;
  assignment_t typed_res = '0;

  // predictor state
  logic [rfha_pkg::ROAD_W-1:0] road_sq = rfha_pkg::ROAD_W'(rfha_pkg::ROAD_RESET);
  rfha_pkg::coord_t            track_end_y [rfha_pkg::MAX_TRACKS];
  rfha_pkg::coord_t            track_end_z [rfha_pkg::MAX_TRACKS];
  int                          tracks_open = 0;
  assignment_t                 pending_assignments [$];

  int mismatches     = 0;
  int hits_seen      = 0;
  int opens_seen     = 0;
  int overflows_seen = 0;
  int road_writes    = 0;
  int cycles         = 0;

  int burst_left     = 0;
  bit steady_sender  = 1'b0;
  int holds_asked    = 0;
  int holds_granted  = 0;
  int hold_left      = 0;

  logic [15:0] ready_pat  = '1;
  logic [5:0]  ready_step = '0;

  road_following_hit_assigner_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("road_following_hit_assigner_unit_test failed");
      $finish;
    end
  end

  // Nearest open track end in squared transverse distance; open a new track
  // when off the road, or join the nearest one when the table is full.
  function automatic assignment_t assign_hit(bit start, rfha_pkg::coord_t y,
                                             rfha_pkg::coord_t z);
    assignment_t res;
    longint      dy;
    longint      dz;
    longint      d;
    longint      best_d;
    int          best;
    bit          found;
    res    = '0;
    best   = 0;
    best_d = 0;
    found  = 1'b0;
    if (start) tracks_open = 0;
    for (int i = 0; i < tracks_open; i++) begin
      dy = longint'(y) - longint'(track_end_y[i]);
      dz = longint'(z) - longint'(track_end_z[i]);
      d  = dy * dy + dz * dz;
      if (!found || d < best_d) begin
        found  = 1'b1;
        best_d = d;
        best   = i;
      end
    end
    if (!found || best_d > longint'(road_sq)) begin
      if (tracks_open < rfha_pkg::MAX_TRACKS) begin
        best        = tracks_open;
        tracks_open = tracks_open + 1;
        res.opened  = 1'b1;
      end else begin
        res.overflow = 1'b1;
      end
    end
    track_end_y[best] = y;
    track_end_z[best] = z;
    res.track = rfha_pkg::OUT_IDX_W'(best);
    return res;
  endfunction

  always @(posedge clk) begin
    assignment_t got;
    assignment_t want;
    assignment_t predicted;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        road_sq     <= cfg_data;
        road_writes <= road_writes + 1;
      end
      if (in_tvalid && in_tready) begin
        predicted = assign_hit(in_tuser[0], rfha_pkg::coord_t'(in_tdata[16:0]),
                               rfha_pkg::coord_t'(in_tdata[33:17]));
        pending_assignments = {pending_assignments, (typed_on ? typed_res : predicted)};
        hits_seen      <= hits_seen + 1;
        opens_seen     <= opens_seen + predicted.opened;
        overflows_seen <= overflows_seen + predicted.overflow;
      end
      if (out_tvalid && out_tready) begin
        got = '{out_tdata[5:0], out_tuser[0], out_tuser[1]};
        if (pending_assignments.size() == 0) begin
          mismatches = mismatches + 1;
          $error("unexpected result transfer: track_index %0d", got.track);
        end else begin
          want = pending_assignments.pop_front();
          if (got.track != want.track) begin
            mismatches = mismatches + 1;
            $error("track_index: expected %0d, got %0d", want.track, got.track);
          end
          if (got.opened != want.opened) begin
            mismatches = mismatches + 1;
            $error("opened_track: expected %0d, got %0d", want.opened, got.opened);
          end
          if (got.overflow != want.overflow) begin
            mismatches = mismatches + 1;
            $error("table_overflow: expected %0d, got %0d", want.overflow, got.overflow);
          end
        end
      end
    end
  end

  // Receiver: a 16-step ready pattern, reloaded each time the 6-bit step counter
  // wraps, plus long hold-offs on request.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (holds_granted != holds_asked) begin
      holds_granted <= holds_granted + 1;
      hold_left     <= LONG_HOLD;
      out_tready    <= 1'b0;
    end else begin
      if (ready_step == 0) begin
        case ($urandom_range(0, 3))
          0:       ready_pat = '1;
          1:       ready_pat = 16'($urandom);
          2:       ready_pat = 16'($urandom) & 16'($urandom);
          default: ready_pat = 16'($urandom) | 16'($urandom);
        endcase
      end
      out_tready <= ready_pat[ready_step[3:0]];
      ready_step = ready_step + 1'b1;
    end
  end

  task automatic offer_hit(bit start, rfha_pkg::coord_t y, rfha_pkg::coord_t z, bit typed,
                           assignment_t res);
    int gap;
    if (burst_left == 0) begin
      gap = steady_sender ? 0 : ($urandom_range(0, 3) == 0 ? $urandom_range(4, 12)
                                                          : $urandom_range(0, 3));
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, z, y};
    in_tuser  <= start;
    typed_on  <= typed;
    typed_res <= res;
    do @(posedge clk); while (!in_tready);
    burst_left = burst_left - 1;
  endtask

  task automatic write_road(logic [rfha_pkg::ROAD_W-1:0] value);
    in_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending_assignments.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic rfha_pkg::coord_t nudge(rfha_pkg::coord_t base, int spread);
    int v;
    v = int'(base) - spread + int'($urandom_range(0, 2 * spread));
    if (v > 65535) v = 65535;
    if (v < -65536) v = -65536;
    return rfha_pkg::coord_t'(v);
  endfunction

  task automatic run_event(int len);
    rfha_pkg::coord_t y;
    rfha_pkg::coord_t z;
    int     roll;
    int     t;
    int     g;
    int     spreads [4] = '{2, 60, 400, 3000};
    for (int k = 0; k < len; k++) begin
      roll = $urandom_range(0, 99);
      if (tracks_open != 0 && roll < 65) begin
        // follow an open track
        t = $urandom_range(0, tracks_open - 1);
        g = spreads[$urandom_range(0, 3)];
        y = nudge(track_end_y[t], g);
        z = nudge(track_end_z[t], g);
      end else if (roll < 85) begin
        y = rfha_pkg::coord_t'($urandom);
        z = rfha_pkg::coord_t'($urandom);
      end else begin
        // coarse grid: many equal distances
        g = $urandom_range(0, 8);
        y = rfha_pkg::coord_t'((g - 4) * 40);
        g = $urandom_range(0, 8);
        z = rfha_pkg::coord_t'((g - 4) * 40);
      end
      offer_hit(k == 0 || $urandom_range(0, 49) == 0, y, z, 1'b0, '0);
    end
  endtask

  initial begin
    int          random_hits;
    int          phase;
    int          len;
    logic [rfha_pkg::ROAD_W-1:0] road;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (hit_rows[r]) begin
      offer_hit(hit_rows[r].start[0], rfha_pkg::coord_t'(hit_rows[r].y),
                rfha_pkg::coord_t'(hit_rows[r].z), hit_rows[r].typed[0],
                '{rfha_pkg::OUT_IDX_W'(hit_rows[r].track), hit_rows[r].opened[0],
                  hit_rows[r].overflow[0]});
    end

    random_hits = 0;
    phase       = 0;
    while (random_hits < RANDOM_HITS) begin
      case (phase % 6)
        0:       road = '0;
        1:       road = rfha_pkg::ROAD_W'(rfha_pkg::ROAD_RESET);
        2:       road = ROAD_MAX;
        3:       road = rfha_pkg::ROAD_W'($urandom_range(0, 200000));
        4:       road = rfha_pkg::ROAD_W'(1);
        default: road = rfha_pkg::ROAD_W'({$urandom, $urandom});
      endcase
      write_road(road);
      // fill the table and keep the input pushing while results back up
      steady_sender = (phase == 1 || phase == 4);
      if (steady_sender) holds_asked <= holds_asked + 1;
      for (int e = 0; e < 6; e++) begin
        if (phase == 0 && e == 0) len = 70;
        else if ($urandom_range(0, 99) < 15) len = $urandom_range(64, 90);
        else len = $urandom_range(1, 30);
        run_event(len);
        random_hits = random_hits + len;
      end
      phase = phase + 1;
    end

    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_assignments.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("checked %0d hits over %0d threshold phases and %0d threshold writes",
             hits_seen, phase, road_writes);
    $display("tracks opened %0d, table overflows %0d, receiver long holds %0d",
             opens_seen, overflows_seen, holds_granted);
    if (mismatches == 0)
      $display("road_following_hit_assigner_unit_test passed");
    else
      $display("road_following_hit_assigner_unit_test failed");
    $finish;
  end

endmodule
`default_nettype wire

// ----- sim.f -----
rtl/core/rfha_pkg.sv
rtl/core/road_following_hit_assigner_unit.sv
sim/road_following_hit_assigner_unit_test.sv
